/* rtl/rbvc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbvc_pkg
// Shared types, constants and helpers for the rotated box view cull block.
// ----------------------------------------------------------------------------
package rbvc_pkg;

    localparam int TABLE_INDEX_BITS = 12;
    localparam int QIDX_W           = TABLE_INDEX_BITS - 1;
    localparam int QUARTER          = 1 << (TABLE_INDEX_BITS - 2);
    localparam int TRIG_W           = 15;

    localparam real SIN_STEP = 3.14159265358979323846 / 2.0 / real'(QUARTER);

    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int WIDE_W = 51;

    localparam logic [2:0] CFG_VIEW_LEFT     = 3'd0;
    localparam logic [2:0] CFG_VIEW_RIGHT    = 3'd1;
    localparam logic [2:0] CFG_VIEW_BOTTOM   = 3'd2;
    localparam logic [2:0] CFG_VIEW_TOP      = 3'd3;
    localparam logic [2:0] CFG_VIEW_ZOOM     = 3'd4;
    localparam logic [2:0] CFG_VIEW_CENTER_X = 3'd5;
    localparam logic [2:0] CFG_VIEW_CENTER_Y = 3'd6;

    typedef logic [TRIG_W-1:0] sin_tab_t [0:QUARTER];

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        real      a;
        for (int i = 0; i <= QUARTER; i++)
        begin
            a    = SIN_STEP * real'(i);
            t[i] = TRIG_W'($rtoi($sin(a) * 16384.0 + 0.5));
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = -WIDE_W'(64'sd2147483648);
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/rbvc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rbvc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbvc_div
    import rbvc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quo
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_NUM_W-2:0], qbit};
            rem_next = qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule
`default_nettype wire

/* rtl/rotated_box_view_cull.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_box_view_cull
// Bounding box of a rotated, scaled object and inclusive overlap test
// against the camera box.
// One object per cycle unless a stalled result or a camera rebuild stalls input.
// The six-stage datapath advances as a whole; a stalled result holds it.
// Camera edges come from two bit-serial dividers: after reset and after every
// configuration write, input stays stalled while they rebuild.
// Reset clears control state and loads the default camera registers.
// ----------------------------------------------------------------------------
module rotated_box_view_cull
    import rbvc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] obj_x,
    input  wire logic signed [31:0] obj_y,
    input  wire logic signed [31:0] obj_scale_x,
    input  wire logic signed [31:0] obj_scale_y,
    input  wire logic signed [31:0] obj_size_x,
    input  wire logic signed [31:0] obj_size_y,
    input  wire logic [15:0]        obj_angle,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    visible,
    output logic signed [31:0]      box_left,
    output logic signed [31:0]      box_right,
    output logic signed [31:0]      box_bottom,
    output logic signed [31:0]      box_top
);

    typedef enum logic [1:0] {CAM_START, CAM_DIV, CAM_EDGE, CAM_READY} cam_state_t;

    cam_state_t cam_state_reg;

    logic signed [31:0] left_reg, right_reg, bottom_reg, top_reg;
    logic signed [31:0] vcx_reg, vcy_reg;
    logic [30:0]        zoom_reg;
    logic signed [31:0] cam_l_reg, cam_r_reg, cam_b_reg, cam_t_reg;

    logic signed [32:0]   diff_x, diff_y;
    logic [31:0]          mag_x, mag_y;
    logic [30:0]          zoom_eff;
    logic [DIV_NUM_W-1:0] num_x, num_y, quo_x, quo_y;
    logic [DIV_DEN_W-1:0] den;
    logic                 div_start, done_x, done_y;
    logic signed [WIDE_W-1:0] hw, hh, vcx_w, vcy_w;

    always_comb
    begin
        diff_x    = 33'(right_reg) - 33'(left_reg);
        diff_y    = 33'(top_reg) - 33'(bottom_reg);
        mag_x     = diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
        mag_y     = diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
        zoom_eff  = (zoom_reg == '0) ? 31'd1 : zoom_reg;
        num_x     = DIV_NUM_W'({mag_x, 16'b0}) + DIV_NUM_W'(zoom_eff);
        num_y     = DIV_NUM_W'({mag_y, 16'b0}) + DIV_NUM_W'(zoom_eff);
        den       = {zoom_eff, 1'b0};
        div_start = (cam_state_reg == CAM_START) && !cfg_we;
        hw        = diff_x[32] ? -$signed(WIDE_W'(quo_x)) : $signed(WIDE_W'(quo_x));
        hh        = diff_y[32] ? -$signed(WIDE_W'(quo_y)) : $signed(WIDE_W'(quo_y));
        vcx_w     = WIDE_W'(vcx_reg);
        vcy_w     = WIDE_W'(vcy_reg);
    end

    rbvc_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x),
        .den   (den),
        .done  (done_x),
        .quo   (quo_x)
    );

    rbvc_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y),
        .den   (den),
        .done  (done_y),
        .quo   (quo_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_state_reg <= CAM_START;
            left_reg      <= -32'sd65536;
            right_reg     <= 32'sd65536;
            bottom_reg    <= -32'sd65536;
            top_reg       <= 32'sd65536;
            zoom_reg      <= 31'd65536;
            vcx_reg       <= '0;
            vcy_reg       <= '0;
        end
        else if (cfg_we)
        begin
            cam_state_reg <= CAM_START;
            case (cfg_index)
                CFG_VIEW_LEFT:     left_reg   <= cfg_data;
                CFG_VIEW_RIGHT:    right_reg  <= cfg_data;
                CFG_VIEW_BOTTOM:   bottom_reg <= cfg_data;
                CFG_VIEW_TOP:      top_reg    <= cfg_data;
                CFG_VIEW_ZOOM:     zoom_reg   <= cfg_data[30:0];
                CFG_VIEW_CENTER_X: vcx_reg    <= cfg_data;
                CFG_VIEW_CENTER_Y: vcy_reg    <= cfg_data;
                default:           ;
            endcase
        end
        else
        begin
            case (cam_state_reg)
                CAM_START: cam_state_reg <= CAM_DIV;
                CAM_DIV:   if (done_x) cam_state_reg <= CAM_EDGE;
                CAM_EDGE:  cam_state_reg <= CAM_READY;
                default:   cam_state_reg <= cam_state_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cam_state_reg == CAM_EDGE)
        begin
            cam_l_reg <= sat32(vcx_w - hw);
            cam_r_reg <= sat32(vcx_w + hw);
            cam_b_reg <= sat32(vcy_w - hh);
            cam_t_reg <= sat32(vcy_w + hh);
        end
    end

    // datapath
    logic adv;
    logic [5:0] v_reg;

    logic signed [63:0] p1x_reg, p1y_reg;
    logic [TRIG_W-1:0]  as1_reg, ac1_reg;
    logic signed [31:0] cx1_reg, cy1_reg;

    logic [30:0]        hx2_reg, hy2_reg;
    logic [TRIG_W-1:0]  as2_reg, ac2_reg;
    logic signed [31:0] cx2_reg, cy2_reg;

    logic [45:0]        m_xc3_reg, m_ys3_reg, m_xs3_reg, m_yc3_reg;
    logic signed [31:0] cx3_reg, cy3_reg;

    logic [46:0]        ex4_reg, ey4_reg;
    logic signed [31:0] cx4_reg, cy4_reg;

    logic signed [31:0] bl5_reg, br5_reg, bb5_reg, bt5_reg;

    logic               vis6_reg;
    logic signed [31:0] bl6_reg, br6_reg, bb6_reg, bt6_reg;

    logic [TABLE_INDEX_BITS-1:0] idx;
    logic [QIDX_W-1:0]           ra, rb, si, ci;
    logic [63:0]                 mx, my;
    logic [47:0]                 hx48, hy48;

    function automatic logic [30:0] sat_h(input logic [47:0] h);
        return (h > 48'h7FFFFFFF) ? 31'h7FFFFFFF : h[30:0];
    endfunction

    function automatic logic signed [31:0] edge_round(
        input logic signed [31:0] c,
        input logic [46:0]        e,
        input logic               add
    );
        logic signed [49:0] cw;
        logic signed [49:0] v;
        cw = 50'(c) <<< 14;
        v  = add ? cw + $signed({3'b0, e}) : cw - $signed({3'b0, e});
        v  = v + 50'sd8192;
        return sat32(WIDE_W'(v >>> 14));
    endfunction

    always_comb
    begin
        adv  = !(out_valid && out_stall);
        idx  = obj_angle[15 -: TABLE_INDEX_BITS];
        ra   = {1'b0, idx[TABLE_INDEX_BITS-3:0]};
        rb   = QIDX_W'(QUARTER) - ra;
        si   = idx[TABLE_INDEX_BITS-2] ? rb : ra;
        ci   = idx[TABLE_INDEX_BITS-2] ? ra : rb;
        mx   = p1x_reg[63] ? 64'(-p1x_reg) : 64'(p1x_reg);
        my   = p1y_reg[63] ? 64'(-p1y_reg) : 64'(p1y_reg);
        hx48 = 48'((mx + 64'd32768) >> 16);
        hy48 = 48'((my + 64'd32768) >> 16);
    end

    assign in_stall = !adv || (cam_state_reg != CAM_READY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[4:0], in_valid && !in_stall};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1x_reg   <= obj_size_x * obj_scale_x;
            p1y_reg   <= obj_size_y * obj_scale_y;
            as1_reg   <= SIN_TAB[si];
            ac1_reg   <= SIN_TAB[ci];
            cx1_reg   <= obj_x;
            cy1_reg   <= obj_y;

            hx2_reg   <= sat_h(hx48);
            hy2_reg   <= sat_h(hy48);
            as2_reg   <= as1_reg;
            ac2_reg   <= ac1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;

            m_xc3_reg <= 46'(hx2_reg) * 46'(ac2_reg);
            m_ys3_reg <= 46'(hy2_reg) * 46'(as2_reg);
            m_xs3_reg <= 46'(hx2_reg) * 46'(as2_reg);
            m_yc3_reg <= 46'(hy2_reg) * 46'(ac2_reg);
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;

            ex4_reg   <= 47'(m_xc3_reg) + 47'(m_ys3_reg);
            ey4_reg   <= 47'(m_xs3_reg) + 47'(m_yc3_reg);
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;

            bl5_reg   <= edge_round(cx4_reg, ex4_reg, 1'b0);
            br5_reg   <= edge_round(cx4_reg, ex4_reg, 1'b1);
            bb5_reg   <= edge_round(cy4_reg, ey4_reg, 1'b0);
            bt5_reg   <= edge_round(cy4_reg, ey4_reg, 1'b1);

            vis6_reg  <= (br5_reg >= cam_l_reg) && (bl5_reg <= cam_r_reg) &&
                         (bt5_reg >= cam_b_reg) && (bb5_reg <= cam_t_reg);
            bl6_reg   <= bl5_reg;
            br6_reg   <= br5_reg;
            bb6_reg   <= bb5_reg;
            bt6_reg   <= bt5_reg;
        end
    end

    assign out_valid  = v_reg[5];
    assign visible    = vis6_reg;
    assign box_left   = bl6_reg;
    assign box_right  = br6_reg;
    assign box_bottom = bb6_reg;
    assign box_top    = bt6_reg;

    a_in_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (cam_state_reg == CAM_READY))
        else $error("input transfer while camera edges rebuild");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (cam_state_reg == CAM_START))
        else $error("configuration write did not restart camera edges");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((box_left <= box_right) && (box_bottom <= box_top)))
        else $error("box edges out of order");

    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        done_x == done_y)
        else $error("camera dividers out of step");

endmodule
`default_nettype wire
